// File: rtl/slot_allocator_reuse_delay_macros.svh
// ----------------------------------------------------------------------------
// slot allocator assertion macros
// shared property wrappers, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef SLOT_ALLOCATOR_REUSE_DELAY_MACROS_SVH
`define SLOT_ALLOCATOR_REUSE_DELAY_MACROS_SVH

// same-cycle implication
`define SAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sar_pkg.sv
// ----------------------------------------------------------------------------
// sar_pkg
// widths, reset values and codes shared by the slot allocator files
// ----------------------------------------------------------------------------
`default_nettype none

package sar_pkg;

    localparam int TOTAL_SLOTS_DEF    = 1024;
    localparam int RESERVED_SLOTS_DEF = 64;

    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;
    localparam int SLOT_W    = 10;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int MEM_W     = TIME_W + 1;

    localparam logic [MS_W-1:0] GRACE_RST = 16'd2000;
    localparam logic [MS_W-1:0] REUSE_RST = 16'd1000;

    localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FREED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REUSE       = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

endpackage

`default_nettype wire

// File: rtl/sar_ram.sv
// ----------------------------------------------------------------------------
// sar_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/slot_allocator_reuse_delay.sv
// ----------------------------------------------------------------------------
// slot_allocator_reuse_delay
// first-fit slot allocator with high-water mark and reuse delay
// ----------------------------------------------------------------------------
// After reset the slot table is cleared one entry per cycle with busy
// high. A request is taken when start is high and busy is low; its result
// appears on the output ports for exactly one cycle with done high and
// cannot be held off. A free request answers in the cycle after it is
// taken. An allocate request walks the slot ram one entry per cycle from
// RESERVED_SLOTS up to the high-water mark; if the walk comes up empty the
// table grows through a read and a write state, and when the table is at
// its limit a forced second walk follows. The slot ram has a single read
// port. Busy is high for the whole of an allocation.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_allocator_reuse_delay #(
    parameter int TOTAL_SLOTS    = sar_pkg::TOTAL_SLOTS_DEF,
    parameter int RESERVED_SLOTS = sar_pkg::RESERVED_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           req_type,
    input  logic [sar_pkg::SLOT_W-1:0]     slot_index,
    input  logic [sar_pkg::TIME_W-1:0]     now,
    output logic                           done,
    output logic [sar_pkg::STATUS_W-1:0]   status,
    output logic [sar_pkg::SLOT_W-1:0]     granted_slot,
    output logic                           grew,
    output logic [sar_pkg::COUNT_W-1:0]    slot_count,
    input  logic                           cfg_we,
    input  logic [sar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sar_pkg::TIME_W-1:0]     cfg_wdata
);

    import sar_pkg::*;

    localparam int IW     = $clog2(TOTAL_SLOTS);
    localparam int HW_MAX = (TOTAL_SLOTS > RESERVED_SLOTS) ? TOTAL_SLOTS : RESERVED_SLOTS;
    localparam int HW_W   = $clog2(HW_MAX + 1);
    localparam logic [HW_W-1:0] TOT_HW = HW_W'(TOTAL_SLOTS);
    localparam logic [HW_W-1:0] RES_HW = HW_W'(RESERVED_SLOTS);
    localparam logic [IW-1:0]   LAST_IDX = IW'(TOTAL_SLOTS - 1);

    typedef enum logic [4:0] {
        S_CLEAR   = 5'b00001,
        S_IDLE    = 5'b00010,
        S_SCAN    = 5'b00100,
        S_GROW_RD = 5'b01000,
        S_GROW_WR = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [TIME_W-1:0]   lst_reg;
    logic [MS_W-1:0]     grace_reg;
    logic [MS_W-1:0]     reuse_reg;

    logic [HW_W-1:0]     hw_reg, hw_next;
    logic [HW_W-1:0]     addr_reg, addr_next;
    logic                force_reg, force_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [IW-1:0]       rd_idx_reg, rd_idx_next;
    logic [TIME_W-1:0]   now_reg, now_next;

    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IW-1:0]       granted_reg, granted_next;
    logic                grew_reg, grew_next;

    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic [MEM_W-1:0]    mem_wdata;
    logic                mem_re;
    logic [IW-1:0]       mem_raddr;
    logic [MEM_W-1:0]    mem_rdata;

    logic [HW_W-1:0]     top;
    logic                issue;
    logic                accept;
    logic                idx_in_range;
    logic [IW+SLOT_W-1:0] idx_ext;
    logic [TIME_W:0]     limit;
    logic [TIME_W-1:0]   age;
    logic                recent;
    logic                eligible;
    logic                found;
    logic [IW+SLOT_W-1:0] gr_ext;
    logic [HW_W+COUNT_W-1:0] cnt_ext;

    sar_ram #(
        .WIDTH (MEM_W),
        .DEPTH (TOTAL_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lst_reg   <= '0;
            grace_reg <= GRACE_RST;
            reuse_reg <= REUSE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEVEL_START: lst_reg   <= cfg_wdata;
                CFG_GRACE:       grace_reg <= cfg_wdata[MS_W-1:0];
                CFG_REUSE:       reuse_reg <= cfg_wdata[MS_W-1:0];
                default:         ;
            endcase
        end
    end

    assign accept       = start && !busy;
    assign top          = (hw_reg < TOT_HW) ? hw_reg : TOT_HW;
    assign issue        = (state_reg == S_SCAN) && (addr_reg < top);
    assign idx_in_range = {3'b000, slot_index} < 13'(TOTAL_SLOTS);
    assign idx_ext      = {{IW{1'b0}}, slot_index};

    // recently freed: freed after the grace window and younger than the delay
    assign limit    = {1'b0, lst_reg} + {{(TIME_W - MS_W + 1){1'b0}}, grace_reg};
    assign age      = now_reg - mem_rdata[TIME_W-1:0];
    assign recent   = ({1'b0, mem_rdata[TIME_W-1:0]} > limit)
                      && (age < {{(TIME_W - MS_W){1'b0}}, reuse_reg});
    assign eligible = !mem_rdata[TIME_W] && (force_reg || !recent);
    assign found    = rd_pend_reg && eligible;

    always_comb
    begin
        state_next   = state_reg;
        hw_next      = hw_reg;
        addr_next    = addr_reg;
        force_next   = force_reg;
        rd_pend_next = issue;
        rd_idx_next  = addr_reg[IW-1:0];
        now_next     = now_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        granted_next = granted_reg;
        grew_next    = grew_reg;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg[IW-1:0];
        mem_wdata    = '0;
        mem_re       = issue;
        mem_raddr    = addr_reg[IW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg[IW-1:0] == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next   = now;
                    addr_next  = RES_HW;
                    force_next = 1'b0;
                    if (req_type == REQ_FREE)
                    begin
                        mem_we       = idx_in_range;
                        mem_waddr    = idx_ext[IW-1:0];
                        mem_wdata    = {1'b0, now};
                        done_next    = 1'b1;
                        status_next  = ST_FREED;
                        granted_next = '0;
                        grew_next    = 1'b0;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                if (found)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = rd_idx_reg;
                    mem_wdata    = {1'b1, mem_rdata[TIME_W-1:0]};
                    done_next    = 1'b1;
                    status_next  = ST_ALLOC;
                    granted_next = rd_idx_reg;
                    grew_next    = 1'b0;
                    state_next   = S_IDLE;
                end
                else if (!rd_pend_reg && !issue)
                begin
                    // walk came up empty
                    if (!force_reg && (hw_reg < TOT_HW))
                    begin
                        state_next = S_GROW_RD;
                    end
                    else if (!force_reg)
                    begin
                        force_next = 1'b1;
                        addr_next  = RES_HW;
                    end
                    else
                    begin
                        done_next    = 1'b1;
                        status_next  = ST_FULL;
                        granted_next = '0;
                        grew_next    = 1'b0;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_GROW_RD:
            begin
                // fetch the stamp so the write keeps it
                mem_re     = 1'b1;
                mem_raddr  = hw_reg[IW-1:0];
                state_next = S_GROW_WR;
            end
            S_GROW_WR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = hw_reg[IW-1:0];
                mem_wdata    = {1'b1, mem_rdata[TIME_W-1:0]};
                hw_next      = hw_reg + 1'b1;
                done_next    = 1'b1;
                status_next  = ST_ALLOC;
                granted_next = hw_reg[IW-1:0];
                grew_next    = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            hw_reg      <= RES_HW;
            addr_reg    <= '0;
            force_reg   <= 1'b0;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hw_reg      <= hw_next;
            addr_reg    <= addr_next;
            force_reg   <= force_next;
            rd_pend_reg <= rd_pend_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        now_reg     <= now_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        grew_reg    <= grew_next;
    end

    assign gr_ext  = {{SLOT_W{1'b0}}, granted_reg};
    assign cnt_ext = {{COUNT_W{1'b0}}, hw_reg};

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_slot = gr_ext[SLOT_W-1:0];
    assign grew         = grew_reg;
    assign slot_count   = cnt_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/sar_checker.sv
// ----------------------------------------------------------------------------
// sar_checker
// port-level checks on the slot allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "slot_allocator_reuse_delay_macros.svh"

module sar_checker (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire                          busy,
    input  wire                          req_type,
    input  wire                          done,
    input  wire [sar_pkg::STATUS_W-1:0]  status,
    input  wire [sar_pkg::SLOT_W-1:0]    granted_slot,
    input  wire                          grew,
    input  wire [sar_pkg::COUNT_W-1:0]   slot_count
);

    import sar_pkg::*;

    // a free request answers on the very next cycle
    `SAR_ASSERT_NEXT(free_answers_next, start && !busy && (req_type == REQ_FREE), done && (status == ST_FREED), "free request not answered next cycle")

    // only an allocation carries a slot or growth
    `SAR_ASSERT_NOW(idle_fields_zero, done && (status != ST_ALLOC), (granted_slot == '0) && !grew, "non-allocate result carries slot or growth")

    // a result is shown once the block is ready again
    `SAR_ASSERT_NOW(done_when_ready, done, !busy, "result shown while still busy")

    // growth raises the mark by exactly one
    `SAR_ASSERT_NOW(growth_steps_one, done && grew, slot_count == $past(slot_count) + 1'b1, "growth did not raise the mark by one")

    // the mark moves only with growth
    `SAR_ASSERT_NOW(count_moves_on_growth, !(done && grew), $stable(slot_count), "mark changed without growth")

endmodule

bind slot_allocator_reuse_delay sar_checker u_sar_checker (.*);

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// slot allocator testbench
// drives allocate and free requests through the command port, predicts each
// answer from a behavioral copy of the slot table and checks it field by field
// ----------------------------------------------------------------------------

module testbench;

    import sar_pkg::*;

    localparam int SLOTS    = TOTAL_SLOTS_DEF;
    localparam int RESERVED = RESERVED_SLOTS_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                grew;
        logic [COUNT_W-1:0]  count;
    } alloc_result_t;

    class slot_scoreboard;
        bit                slot_busy [SLOTS];
        logic [TIME_W-1:0] freed_at [SLOTS];
        int                high_water;
        logic [TIME_W-1:0] level_start;
        logic [MS_W-1:0]   grace;
        logic [MS_W-1:0]   reuse_delay;
        alloc_result_t     expected_q [$];
        int                errors;
        int                n_alloc;
        int                n_free;
        int                n_grow;
        int                n_forced;
        int                n_full;
        int                n_checked;

        function new();
            foreach (slot_busy[i])
            begin
                slot_busy[i] = 1'b0;
                freed_at[i]  = '0;
            end
            high_water  = RESERVED;
            level_start = '0;
            grace       = GRACE_RST;
            reuse_delay = REUSE_RST;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
            case (idx)
                CFG_LEVEL_START: level_start = data;
                CFG_GRACE:       grace       = data[MS_W-1:0];
                CFG_REUSE:       reuse_delay = data[MS_W-1:0];
                default:         ;
            endcase
        endfunction

        // freed after the grace window and not yet old enough
        function bit recently_freed(int i, logic [TIME_W-1:0] t_ms);
            logic [TIME_W:0]   limit;
            logic [TIME_W-1:0] age;
            limit = {1'b0, level_start} + {{(TIME_W-MS_W+1){1'b0}}, grace};
            age   = t_ms - freed_at[i];
            return ({1'b0, freed_at[i]} > limit) && (age < {{(TIME_W-MS_W){1'b0}}, reuse_delay});
        endfunction

        function int first_fit(bit ignore_delay, logic [TIME_W-1:0] t_ms);
            int top;
            top = (high_water < SLOTS) ? high_water : SLOTS;
            for (int i = RESERVED; i < top; i++)
                if (!slot_busy[i] && (ignore_delay || !recently_freed(i, t_ms)))
                    return i;
            return SLOTS;
        endfunction

        function void note_request(logic req, logic [SLOT_W-1:0] idx, logic [TIME_W-1:0] t_ms);
            alloc_result_t res;
            int            pick;
            res = '0;
            if (req == REQ_FREE)
            begin
                if (idx < SLOTS)
                begin
                    slot_busy[idx] = 1'b0;
                    freed_at[idx]  = t_ms;
                end
                res.status = ST_FREED;
                n_free++;
            end
            else
            begin
                n_alloc++;
                pick = first_fit(1'b0, t_ms);
                if (pick < SLOTS)
                begin
                    slot_busy[pick] = 1'b1;
                    res.slot        = SLOT_W'(pick);
                    res.status      = ST_ALLOC;
                end
                else if (high_water < SLOTS)
                begin
                    slot_busy[high_water] = 1'b1;
                    res.slot   = SLOT_W'(high_water);
                    res.grew   = 1'b1;
                    res.status = ST_ALLOC;
                    high_water++;
                    n_grow++;
                end
                else
                begin
                    // table at its limit: second pass ignores the delay
                    pick = first_fit(1'b1, t_ms);
                    if (pick < SLOTS)
                    begin
                        slot_busy[pick] = 1'b1;
                        res.slot        = SLOT_W'(pick);
                        res.status      = ST_ALLOC;
                        n_forced++;
                    end
                    else
                    begin
                        res.status = ST_FULL;
                        n_full++;
                    end
                end
            end
            res.count = COUNT_W'(high_water);
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val)
            begin
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                                   logic grew, logic [COUNT_W-1:0] count);
            alloc_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("result with no request outstanding: status %0d slot %0d", status, slot);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            n_checked++;
            compare_field("status", exp_res.status, status);
            compare_field("granted_slot", exp_res.slot, slot);
            compare_field("grew", exp_res.grew, grew);
            compare_field("slot_count", exp_res.count, count);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // busy slot from random start, else random in use range, or table if empty
        function int pick_busy();
            int top;
            int span;
            int base;
            top  = (high_water < SLOTS) ? high_water : SLOTS;
            span = top - RESERVED;
            if (span <= 0)
                return $urandom_range(0, SLOTS - 1);
            base = $urandom_range(0, span - 1);
            for (int k = 0; k < span; k++)
                if (slot_busy[RESERVED + (base + k) % span])
                    return RESERVED + (base + k) % span;
            return $urandom_range(RESERVED, top - 1);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic                 req_type     = REQ_ALLOC;
    logic [SLOT_W-1:0]    slot_index   = '0;
    logic [TIME_W-1:0]    now          = '0;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    granted_slot;
    logic                 grew;
    logic [COUNT_W-1:0]   slot_count;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [TIME_W-1:0]    cfg_wdata    = '0;

    slot_scoreboard    sb = new();
    int                burst_left = 0;
    logic [TIME_W-1:0] clock_ms   = 32'd5000;

    slot_allocator_reuse_delay dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(status, granted_slot, grew, slot_count);
    end

    // mostly small steps so the reuse delay matters, now and then a jump
    function automatic logic [TIME_W-1:0] tick_clock();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            clock_ms += $urandom_range(0, 400);
        else if (roll < 95)
            clock_ms += $urandom_range(0, 5000);
        else
            clock_ms = $urandom();
        return clock_ms;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue(logic req, logic [SLOT_W-1:0] idx, logic [TIME_W-1:0] t_ms);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        start      = 1'b1;
        req_type   = req;
        slot_index = idx;
        now        = t_ms;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(req, idx, t_ms);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic wait_idle();
        start = 1'b0;
        while (sb.pending() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic setup(logic [TIME_W-1:0] start_ms, logic [MS_W-1:0] grace_val,
                         logic [MS_W-1:0] delay_val);
        wait_idle();
        // upper data bits are junk for the 16-bit registers
        write_reg(CFG_LEVEL_START, start_ms);
        write_reg(CFG_GRACE, {16'($urandom()), grace_val});
        write_reg(CFG_REUSE, {16'($urandom()), delay_val});
    endtask

    task automatic random_phase(int count);
        int roll;
        int idx;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                issue(REQ_ALLOC, SLOT_W'($urandom()), tick_clock());
            else
            begin
                if (roll < 80)
                    idx = sb.pick_busy();
                else if (roll < 92)
                    idx = $urandom_range(RESERVED,
                                         (sb.high_water > RESERVED) ? sb.high_water - 1 : RESERVED);
                else
                    idx = $urandom_range(0, SLOTS - 1);
                issue(REQ_FREE, SLOT_W'(idx), tick_clock());
            end
            if ($urandom_range(0, 49) == 0)
                wait_idle();
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        // table clear pass runs with busy high
        wait_idle();

        // directed requests at the reset settings
        issue(REQ_ALLOC, 10'd0, 32'd0);
        issue(REQ_ALLOC, 10'd0, 32'd0);
        issue(REQ_ALLOC, 10'h3FF, 32'd5);
        issue(REQ_FREE, 10'd65, 32'd10);
        issue(REQ_ALLOC, 10'd0, 32'd20);              // freed inside grace, reused
        issue(REQ_FREE, 10'd0, 32'hFFFF_FFFF);        // reserved slot
        issue(REQ_FREE, 10'h3FF, 32'h8000_0000);      // above the mark
        issue(REQ_FREE, 10'd66, 32'd3000);
        issue(REQ_FREE, 10'd66, 32'd3100);            // already free
        issue(REQ_ALLOC, 10'd0, 32'd3200);            // too recent, grows
        issue(REQ_ALLOC, 10'd0, 32'd4200);            // delay elapsed
        issue(REQ_FREE, 10'd64, 32'hFFFF_FF00);
        issue(REQ_ALLOC, 10'h155, 32'h0000_0010);     // age wraps, still recent
        issue(REQ_ALLOC, 10'h2AA, 32'h0000_0400);
        issue(REQ_FREE, 10'h2AA, 32'h5555_5555);
        issue(REQ_FREE, 10'h155, 32'hAAAA_AAAA);
        issue(REQ_FREE, 10'd67, 32'h0000_1000);
        issue(REQ_ALLOC, 10'd0, 32'h0000_1001);
        issue(REQ_ALLOC, 10'd0, 32'h0000_1002);

        setup(clock_ms, 16'd0, 16'hFFFF);
        random_phase(60);
        setup(32'hFFFF_FFFF, 16'hFFFF, 16'd0);
        random_phase(60);
        setup(clock_ms - $urandom_range(0, 3000), 16'($urandom_range(0, 3000)),
              16'($urandom_range(0, 3000)));
        random_phase(60);
        setup(32'd0, 16'd0, 16'd1);
        random_phase(60);
        setup(32'd0, 16'd0, 16'hFFFF);
        random_phase(30);

        wait_idle();
        repeat (2 * SLOTS + 16) @(negedge clk);

        $display("covered %0d allocations (%0d grew the table, %0d by forced pass, %0d full)",
                 sb.n_alloc, sb.n_grow, sb.n_forced, sb.n_full);
        $display("and %0d frees; %0d answers checked, final mark %0d",
                 sb.n_free, sb.n_checked, sb.high_water);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
